// ===== hw/rtl/ipwp_pkg.sv =====
package ipwp_pkg;

	localparam int unsigned WinLen = 11;
	localparam int unsigned HoldLen = WinLen - 1;

	localparam logic [7:0] SYNC_BYTE  = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_GYRO  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;

	localparam int unsigned OutDataW = 56;

	typedef struct packed {
		logic signed [15:0] value_z;
		logic signed [15:0] value_y;
		logic signed [15:0] value_x;
		logic [1:0]         packet_kind;
	} result_t;

endpackage

// ===== hw/rtl/ipwp_front.sv =====
module ipwp_front
	import ipwp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       push,
	output result_t    push_data
);

	logic [7:0] window_q [HoldLen];
	logic [3:0] fill_q;
	logic [7:0] sum_q;
	logic       full;
	logic       type_ok;
	logic       good;
	logic [7:0] kind_code;

	assign full      = (fill_q == 4'(HoldLen));
	assign type_ok   = (window_q[1] == TYPE_ACCEL) || (window_q[1] == TYPE_GYRO)
		|| (window_q[1] == TYPE_ANGLE);
	assign good      = full && (window_q[0] == SYNC_BYTE) && type_ok && (sum_q == rx_byte);
	assign kind_code = window_q[1] - TYPE_ACCEL;

	assign push                  = accept && good;
	assign push_data.packet_kind = kind_code[1:0];
	assign push_data.value_x     = {window_q[3], window_q[2]};
	assign push_data.value_y     = {window_q[5], window_q[4]};
	assign push_data.value_z     = {window_q[7], window_q[6]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (!full) begin
				fill_q <= fill_q + 4'd1;
				sum_q  <= sum_q + rx_byte;
			end else if (good) begin
				fill_q <= '0;
				sum_q  <= '0;
			end else begin
				sum_q <= sum_q - window_q[0] + rx_byte;
			end
		end
	end

	// append below the fill mark, or drop the oldest byte and shift in
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!full) begin
				window_q[fill_q] <= rx_byte;
			end else if (!good) begin
				for (int i = 0; i < HoldLen - 1; i++) begin
					window_q[i] <= window_q[i + 1];
				end
				window_q[HoldLen - 1] <= rx_byte;
			end
		end
	end

endmodule

// ===== hw/rtl/ipwp_fifo.sv =====
module ipwp_fifo
	import ipwp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	input  logic    pop,
	output logic    avail,
	output result_t pop_data
);

	localparam int unsigned Depth = 2;

	result_t    mem_q [Depth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign space    = (count_q != 2'(Depth));
	assign avail    = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/ipwp_back.sv =====
module ipwp_back
	import ipwp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avail,
	input  result_t             pop_data,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata
);

	logic    valid_q;
	result_t data_q;

	assign pop           = avail && (!valid_q || m_axis_tready);
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= pop_data;
		end
	end

endmodule

// ===== hw/rtl/imu_packet_window_parser_top.sv =====
// A packet's result passes the queue and then the output register before m_axis_tvalid rises.
// Throughput: one byte per cycle unless the queue fills; a running sum checks each window.
// A two-entry result queue and an output register let the input run while m_axis stalls.
// Reset: arst_n clears the fill count, running sum, queue and output valid at once.
module imu_packet_window_parser_top
	import ipwp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,  // [7:0] rx_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [1:0] packet_kind, [17:2] value_x, [33:18] value_y, [49:34] value_z, [55:50] zero
	output logic [OutDataW-1:0] m_axis_tdata
);

	logic    accept;
	logic    push;
	result_t push_data;
	logic    space;
	logic    pop;
	logic    avail;
	result_t pop_data;

	assign s_axis_tready = space;
	assign accept        = s_axis_tvalid && space;

	ipwp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (s_axis_tdata),
		.push      (push),
		.push_data (push_data)
	);

	ipwp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (space),
		.pop       (pop),
		.avail     (avail),
		.pop_data  (pop_data)
	);

	ipwp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.avail         (avail),
		.pop_data      (pop_data),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
